/* hdl/sprite_sheet_frame_animator_core_assert.svh */
// Assertion macros shared by the RTL of the frame animator.
`ifndef SPRITE_SHEET_FRAME_ANIMATOR_CORE_ASSERT_SVH
`define SPRITE_SHEET_FRAME_ANIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSFA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ssfa_pkg.sv */
package ssfa_pkg;

   localparam int MAX_FRAMES = 1024;
   localparam int FRAC_BITS  = 16;
   localparam int RATE_W     = 16;
   localparam int RATE_FRAC  = 8;
   localparam int DT_W       = 16;
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = FRAME_W + 1;
   localparam int WHOLE_W    = RATE_W - RATE_FRAC + 1;
   localparam int ACC_W      = WHOLE_W + FRAC_BITS;
   localparam int DIV_W      = COUNT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int PITCH_W    = 13;
   localparam int ORIGIN_W   = 22;
   localparam int EVENTS_W   = 8;
   localparam int PROD_W     = RATE_W + DT_W;
   localparam int MX_W       = PITCH_W + FRAME_W;
   localparam int STEP_W     = $clog2(DT_W + 1);
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 3;

   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;

   localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [IDX_W-1:0] REG_RATE      = 3'd1;
   localparam logic [IDX_W-1:0] REG_PITCH_X   = 3'd2;
   localparam logic [IDX_W-1:0] REG_PITCH_Y   = 3'd3;
   localparam logic [IDX_W-1:0] REG_COUNT     = 3'd4;
   localparam logic [IDX_W-1:0] REG_PER_ROW   = 3'd5;
   localparam logic [IDX_W-1:0] REG_START     = 3'd6;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_ACC  = 7'b0000100,
      ST_WRAP = 7'b0001000,
      ST_POS  = 7'b0010000,
      ST_ORG  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
   } div_status_type;

endpackage

/* hdl/ssfa_div.sv */
module ssfa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  ssfa_pkg::div_req_type       req,
   output ssfa_pkg::div_status_type    status,
   output logic [ssfa_pkg::DIV_W-1:0]  quot,
   output logic [ssfa_pkg::DIV_W-1:0]  rem
);

   logic [ssfa_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [ssfa_pkg::DIV_W-1:0]     quo_ff;
   logic [ssfa_pkg::DIV_W-1:0]     dsr_ff;
   logic [ssfa_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [ssfa_pkg::DIV_W:0]       part;
   logic [ssfa_pkg::DIV_W-1:0]     diff;
   logic                           fits;

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      part   = {rem_ff, quo_ff[ssfa_pkg::DIV_W-1]};
      diff   = part[ssfa_pkg::DIV_W-1:0] - dsr_ff;
      fits   = (part >= {1'b0, dsr_ff});
      rem_in = fits ? diff : part[ssfa_pkg::DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ssfa_pkg::DIV_CNT_W'(ssfa_pkg::DIV_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[ssfa_pkg::DIV_W-2:0], fits};
      end
   end

   assign status.done = done_ff;
   assign quot        = quo_ff;
   assign rem         = rem_ff;

endmodule

/* hdl/sprite_sheet_frame_animator_core.sv */
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | req_delta_time
// rsp      | out       | rsp_valid/rsp_stall  | rsp_frame_index, rsp_origin_x, rsp_origin_y,
//          |           |                      | rsp_advanced, rsp_end_events
// csr      | in/out    | csr_psel/csr_penable | csr_paddr, csr_pwdata, csr_prdata
//
// One transaction at a time.
// Per-second mode adds a bit-serial rate times time multiply; each serial divide (wrap, only
// when the frame moves, then row/column) adds its own steps; origins are shift-add products.
// Reset is synchronous; it clears the accumulator and frame and resets the registers.
// A finished result waits in the output register while rsp_stall is high;
// the next transaction is accepted meanwhile.
`include "sprite_sheet_frame_animator_core_assert.svh"

module sprite_sheet_frame_animator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ssfa_pkg::DT_W-1:0]         req_delta_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ssfa_pkg::FRAME_W-1:0]      rsp_frame_index,
   output logic [ssfa_pkg::ORIGIN_W-1:0]     rsp_origin_x,
   output logic [ssfa_pkg::ORIGIN_W-1:0]     rsp_origin_y,
   output logic                              rsp_advanced,
   output logic [ssfa_pkg::EVENTS_W-1:0]     rsp_end_events,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ssfa_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [ssfa_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [ssfa_pkg::DATA_W-1:0]       csr_prdata,
   output logic                              csr_pready
);

   // configuration
   logic [ssfa_pkg::MODE_W-1:0]   mode_ff;
   logic [ssfa_pkg::RATE_W-1:0]   rate_ff;
   logic [ssfa_pkg::PITCH_W-1:0]  pitch_x_ff;
   logic [ssfa_pkg::PITCH_W-1:0]  pitch_y_ff;
   logic [ssfa_pkg::COUNT_W-1:0]  count_ff;
   logic [ssfa_pkg::COUNT_W-1:0]  per_row_ff;
   logic [ssfa_pkg::FRAME_W-1:0]  start_ff;

   // animation state and control
   ssfa_pkg::state_type           state_ff, state_in;
   logic [ssfa_pkg::ACC_W-1:0]    acc_ff;
   logic [ssfa_pkg::FRAME_W-1:0]  cur_ff;
   logic [ssfa_pkg::STEP_W-1:0]   step_ff;
   logic                          rsp_valid_ff;

   // serial datapath
   logic [ssfa_pkg::PROD_W-1:0]   prod_ff;
   logic [ssfa_pkg::MX_W-1:0]     px_ff;
   logic [ssfa_pkg::MX_W-1:0]     py_ff;
   logic                          adv_ff;
   logic [ssfa_pkg::EVENTS_W-1:0] events_ff;

   // output register
   logic [ssfa_pkg::FRAME_W-1:0]  out_frame_ff;
   logic [ssfa_pkg::ORIGIN_W-1:0] out_x_ff;
   logic [ssfa_pkg::ORIGIN_W-1:0] out_y_ff;
   logic                          out_adv_ff;
   logic [ssfa_pkg::EVENTS_W-1:0] out_events_ff;

   logic                          wr_en;
   logic [ssfa_pkg::IDX_W-1:0]    wr_idx;
   logic [ssfa_pkg::COUNT_W-1:0]  count_eff;
   logic [ssfa_pkg::COUNT_W-1:0]  per_row_eff;
   logic                          active;
   logic [ssfa_pkg::ACC_W-1:0]    inc;
   logic [ssfa_pkg::ACC_W-1:0]    acc_sum;
   logic [ssfa_pkg::WHOLE_W-1:0]  whole;
   logic                          do_wrap;
   logic                          req_fire;
   logic                          rsp_fire;
   logic                          out_free;
   logic [ssfa_pkg::RATE_W:0]     mul_sum;
   logic [ssfa_pkg::PITCH_W:0]    px_sum;
   logic [ssfa_pkg::PITCH_W:0]    py_sum;

   ssfa_pkg::div_req_type         div_req;
   ssfa_pkg::div_status_type      div_status;
   logic [ssfa_pkg::DIV_W-1:0]    div_quot;
   logic [ssfa_pkg::DIV_W-1:0]    div_rem;

   ssfa_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .status (div_status),
      .quot   (div_quot),
      .rem    (div_rem)
   );

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_idx     = csr_paddr[ssfa_pkg::ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (wr_idx)
         ssfa_pkg::REG_MODE:    csr_prdata = ssfa_pkg::DATA_W'(mode_ff);
         ssfa_pkg::REG_RATE:    csr_prdata = ssfa_pkg::DATA_W'(rate_ff);
         ssfa_pkg::REG_PITCH_X: csr_prdata = ssfa_pkg::DATA_W'(pitch_x_ff);
         ssfa_pkg::REG_PITCH_Y: csr_prdata = ssfa_pkg::DATA_W'(pitch_y_ff);
         ssfa_pkg::REG_COUNT:   csr_prdata = ssfa_pkg::DATA_W'(count_ff);
         ssfa_pkg::REG_PER_ROW: csr_prdata = ssfa_pkg::DATA_W'(per_row_ff);
         ssfa_pkg::REG_START:   csr_prdata = ssfa_pkg::DATA_W'(start_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // clamp frame count to 1..MAX_FRAMES, row length to at least 1
   always_comb begin
      if (count_ff == '0) begin
         count_eff = ssfa_pkg::COUNT_W'(1);
      end else if (count_ff > ssfa_pkg::COUNT_W'(ssfa_pkg::MAX_FRAMES)) begin
         count_eff = ssfa_pkg::COUNT_W'(ssfa_pkg::MAX_FRAMES);
      end else begin
         count_eff = count_ff;
      end
      per_row_eff = (per_row_ff == '0) ? ssfa_pkg::COUNT_W'(1) : per_row_ff;
   end

   always_comb begin
      case (mode_ff)
         ssfa_pkg::MODE_TICK: begin
            active = 1'b1;
            inc    = ssfa_pkg::ACC_W'(rate_ff) << (ssfa_pkg::FRAC_BITS - ssfa_pkg::RATE_FRAC);
         end
         ssfa_pkg::MODE_SECOND: begin
            active = 1'b1;
            inc    = ssfa_pkg::ACC_W'(prod_ff >>
                     (ssfa_pkg::RATE_FRAC + ssfa_pkg::DT_W - ssfa_pkg::FRAC_BITS));
         end
         default: begin
            active = 1'b0;
            inc    = '0;
         end
      endcase
      acc_sum = acc_ff + inc;
      whole   = acc_sum[ssfa_pkg::ACC_W-1:ssfa_pkg::FRAC_BITS];
      do_wrap = active & (whole != '0);
   end

   // shift-add steps: add the multiplicand when the low bit is set, then shift right
   always_comb begin
      mul_sum = {1'b0, prod_ff[ssfa_pkg::PROD_W-1:ssfa_pkg::DT_W]}
              + (prod_ff[0] ? {1'b0, rate_ff} : '0);
      px_sum  = {1'b0, px_ff[ssfa_pkg::MX_W-1:ssfa_pkg::FRAME_W]}
              + (px_ff[0] ? {1'b0, pitch_x_ff} : '0);
      py_sum  = {1'b0, py_ff[ssfa_pkg::MX_W-1:ssfa_pkg::FRAME_W]}
              + (py_ff[0] ? {1'b0, pitch_y_ff} : '0);
   end

   assign req_stall = (state_ff != ssfa_pkg::ST_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_fire  = rsp_valid_ff & ~rsp_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = ssfa_pkg::DIV_W'(cur_ff);
      div_req.divisor  = per_row_eff;
      case (state_ff)
         ssfa_pkg::ST_ACC: begin
            div_req.start = 1'b1;
            if (do_wrap) begin
               div_req.dividend = ssfa_pkg::DIV_W'(cur_ff) + ssfa_pkg::DIV_W'(whole);
               div_req.divisor  = count_eff;
            end
         end
         ssfa_pkg::ST_WRAP: begin
            div_req.start    = div_status.done;
            div_req.dividend = ssfa_pkg::DIV_W'(div_rem[ssfa_pkg::FRAME_W-1:0]);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssfa_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (mode_ff == ssfa_pkg::MODE_SECOND) ? ssfa_pkg::ST_MUL
                                                             : ssfa_pkg::ST_ACC;
            end
         end
         ssfa_pkg::ST_MUL: begin
            if (step_ff == '0) begin
               state_in = ssfa_pkg::ST_ACC;
            end
         end
         ssfa_pkg::ST_ACC: begin
            state_in = do_wrap ? ssfa_pkg::ST_WRAP : ssfa_pkg::ST_POS;
         end
         ssfa_pkg::ST_WRAP: begin
            if (div_status.done) begin
               state_in = ssfa_pkg::ST_POS;
            end
         end
         ssfa_pkg::ST_POS: begin
            if (div_status.done) begin
               state_in = ssfa_pkg::ST_ORG;
            end
         end
         ssfa_pkg::ST_ORG: begin
            if (step_ff == '0) begin
               state_in = ssfa_pkg::ST_DONE;
            end
         end
         ssfa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ssfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssfa_pkg::ST_IDLE;
         mode_ff      <= ssfa_pkg::MODE_NONE;
         rate_ff      <= '0;
         pitch_x_ff   <= '0;
         pitch_y_ff   <= '0;
         count_ff     <= ssfa_pkg::COUNT_W'(1);
         per_row_ff   <= ssfa_pkg::COUNT_W'(1);
         start_ff     <= '0;
         acc_ff       <= '0;
         cur_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (wr_en) begin
            case (wr_idx)
               ssfa_pkg::REG_MODE:    mode_ff    <= csr_pwdata[ssfa_pkg::MODE_W-1:0];
               ssfa_pkg::REG_RATE:    rate_ff    <= csr_pwdata[ssfa_pkg::RATE_W-1:0];
               ssfa_pkg::REG_PITCH_X: pitch_x_ff <= csr_pwdata[ssfa_pkg::PITCH_W-1:0];
               ssfa_pkg::REG_PITCH_Y: pitch_y_ff <= csr_pwdata[ssfa_pkg::PITCH_W-1:0];
               ssfa_pkg::REG_COUNT:   count_ff   <= csr_pwdata[ssfa_pkg::COUNT_W-1:0];
               ssfa_pkg::REG_PER_ROW: per_row_ff <= csr_pwdata[ssfa_pkg::COUNT_W-1:0];
               ssfa_pkg::REG_START: begin
                  start_ff <= csr_pwdata[ssfa_pkg::FRAME_W-1:0];
                  cur_ff   <= csr_pwdata[ssfa_pkg::FRAME_W-1:0];
               end
               default: begin
               end
            endcase
         end

         case (state_ff)
            ssfa_pkg::ST_IDLE: begin
               step_ff <= ssfa_pkg::STEP_W'(ssfa_pkg::DT_W - 1);
            end
            ssfa_pkg::ST_MUL: begin
               step_ff <= step_ff - 1'b1;
            end
            ssfa_pkg::ST_ACC: begin
               // drop the integer part once it moves the frame
               if (do_wrap) begin
                  acc_ff <= {{ssfa_pkg::WHOLE_W{1'b0}}, acc_sum[ssfa_pkg::FRAC_BITS-1:0]};
               end else if (active) begin
                  acc_ff <= acc_sum;
               end
            end
            ssfa_pkg::ST_WRAP: begin
               if (div_status.done) begin
                  cur_ff <= div_rem[ssfa_pkg::FRAME_W-1:0];
               end
            end
            ssfa_pkg::ST_POS: begin
               step_ff <= ssfa_pkg::STEP_W'(ssfa_pkg::FRAME_W - 1);
            end
            ssfa_pkg::ST_ORG: begin
               step_ff <= step_ff - 1'b1;
            end
            default: begin
            end
         endcase

         if (state_ff == ssfa_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ssfa_pkg::ST_IDLE: begin
            prod_ff <= {{ssfa_pkg::RATE_W{1'b0}}, req_delta_time};
         end
         ssfa_pkg::ST_MUL: begin
            prod_ff <= {mul_sum, prod_ff[ssfa_pkg::DT_W-1:1]};
         end
         ssfa_pkg::ST_ACC: begin
            adv_ff    <= do_wrap;
            events_ff <= '0;
         end
         ssfa_pkg::ST_WRAP: begin
            if (div_status.done) begin
               // saturate the wrap count
               events_ff <= (|div_quot[ssfa_pkg::DIV_W-1:ssfa_pkg::EVENTS_W])
                          ? {ssfa_pkg::EVENTS_W{1'b1}} : div_quot[ssfa_pkg::EVENTS_W-1:0];
            end
         end
         ssfa_pkg::ST_POS: begin
            px_ff <= {{ssfa_pkg::PITCH_W{1'b0}}, div_rem[ssfa_pkg::FRAME_W-1:0]};
            py_ff <= {{ssfa_pkg::PITCH_W{1'b0}}, div_quot[ssfa_pkg::FRAME_W-1:0]};
         end
         ssfa_pkg::ST_ORG: begin
            px_ff <= {px_sum, px_ff[ssfa_pkg::FRAME_W-1:1]};
            py_ff <= {py_sum, py_ff[ssfa_pkg::FRAME_W-1:1]};
         end
         default: begin
         end
      endcase

      if (state_ff == ssfa_pkg::ST_DONE && out_free) begin
         out_frame_ff  <= cur_ff;
         out_x_ff      <= (|px_ff[ssfa_pkg::MX_W-1:ssfa_pkg::ORIGIN_W])
                        ? {ssfa_pkg::ORIGIN_W{1'b1}} : px_ff[ssfa_pkg::ORIGIN_W-1:0];
         out_y_ff      <= (|py_ff[ssfa_pkg::MX_W-1:ssfa_pkg::ORIGIN_W])
                        ? {ssfa_pkg::ORIGIN_W{1'b1}} : py_ff[ssfa_pkg::ORIGIN_W-1:0];
         out_adv_ff    <= adv_ff;
         out_events_ff <= events_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = out_frame_ff;
   assign rsp_origin_x    = out_x_ff;
   assign rsp_origin_y    = out_y_ff;
   assign rsp_advanced    = out_adv_ff;
   assign rsp_end_events  = out_events_ff;

   `SSFA_ASSERT_SAME(a_div_done_in_div_state,
      div_status.done,
      (state_ff == ssfa_pkg::ST_WRAP) || (state_ff == ssfa_pkg::ST_POS),
      "divider finished outside a divide state")
   `SSFA_ASSERT_SAME(a_events_imply_advance,
      rsp_valid_ff && (out_events_ff != '0),
      out_adv_ff,
      "end events reported without a frame advance")
   `SSFA_ASSERT_SAME(a_idle_acc_fraction_only,
      state_ff == ssfa_pkg::ST_IDLE,
      acc_ff[ssfa_pkg::ACC_W-1:ssfa_pkg::FRAC_BITS] == '0,
      "accumulator holds an integer part while idle")
   `SSFA_ASSERT_NEXT(a_accept_starts_work,
      req_fire,
      (state_ff == ssfa_pkg::ST_MUL) || (state_ff == ssfa_pkg::ST_ACC),
      "accepted transaction did not start the datapath")

endmodule
